/* sv/medht_pkg.sv */
// Package for the mesh edge numbering table: item and result types, hash constants.
// Used by the hash, front, probe and top modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package medht_pkg;

    localparam int CORNER_W = 20;
    localparam int ID_W     = 12;
    localparam int COUNT_W  = 13;

    localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam int FMIX_SHIFT = 33;
    localparam int PAIR_SHIFT = 32;

    localparam logic OP_QUAD  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [CORNER_W-1:0] corner0;
        logic [CORNER_W-1:0] corner1;
        logic [CORNER_W-1:0] corner2;
        logic [CORNER_W-1:0] corner3;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]     edge_id;
        logic                reversed;
        logic                is_new;
        logic [CORNER_W-1:0] start_node;
        logic [CORNER_W-1:0] end_node;
        logic [COUNT_W-1:0]  edge_count;
        logic                overflow;
        logic                last;
    } result_t;

endpackage
`default_nettype wire

/* sv/medht_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module medht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* sv/medht_hash.sv */
// Iterative 64-bit murmur3 finalizer over a (lo, hi) node pair.
// One 32x32 multiplier builds each 64-bit product in three steps. Uses medht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module medht_hash #(
    parameter int NB = 20
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NB-1:0] lo,
    input  wire logic [NB-1:0] hi,
    output logic               done,
    output logic      [63:0]   hash
);

    typedef enum logic { H_IDLE, H_MUL } hstate_t;

    hstate_t     state_reg;
    logic [1:0]  step_reg;
    logic        round_reg;
    logic [63:0] v_reg;
    logic [63:0] acc_reg;
    logic        done_reg;
    logic [63:0] hash_reg;

    logic [63:0] pair;
    logic [63:0] mix_in;
    logic [63:0] c_sel;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [63:0] prod;
    logic [63:0] sum;
    logic [63:0] sum_mix;

    always_comb
    begin
        pair   = (64'(lo) << medht_pkg::PAIR_SHIFT) ^ 64'(hi);
        mix_in = pair ^ (pair >> medht_pkg::FMIX_SHIFT);
        c_sel  = round_reg ? medht_pkg::FMIX_C2 : medht_pkg::FMIX_C1;
        case (step_reg)
            2'd0:
            begin
                opa = v_reg[31:0];
                opb = c_sel[31:0];
            end
            2'd1:
            begin
                opa = v_reg[31:0];
                opb = c_sel[63:32];
            end
            default:
            begin
                opa = v_reg[63:32];
                opb = c_sel[31:0];
            end
        endcase
        prod = 64'(opa) * 64'(opb);
        // Cross terms only reach the upper word of the truncated product.
        sum     = acc_reg + {prod[31:0], 32'b0};
        sum_mix = sum ^ (sum >> medht_pkg::FMIX_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            step_reg  <= 2'd0;
            round_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        v_reg     <= mix_in;
                        step_reg  <= 2'd0;
                        round_reg <= 1'b0;
                        state_reg <= H_MUL;
                    end
                end
                H_MUL:
                begin
                    if (step_reg == 2'd0)
                    begin
                        acc_reg  <= prod;
                        step_reg <= 2'd1;
                    end
                    else if (step_reg == 2'd1)
                    begin
                        acc_reg  <= sum;
                        step_reg <= 2'd2;
                    end
                    else if (!round_reg)
                    begin
                        v_reg     <= sum_mix;
                        round_reg <= 1'b1;
                        step_reg  <= 2'd0;
                    end
                    else
                    begin
                        hash_reg  <= sum_mix;
                        done_reg  <= 1'b1;
                        state_reg <= H_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign hash = hash_reg;

endmodule
`default_nettype wire

/* sv/medht_front.sv */
// Front part: accepts quads and clear commands, hashes each edge and queues edge jobs.
// Instantiates medht_hash. Uses medht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module medht_front #(
    parameter int NB = 20,
    parameter int SB = 12,
    parameter int JW = 2 + SB + 2 * NB
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire medht_pkg::item_t      item,
    output logic                       job_push,
    output logic [JW-1:0]              job,
    input  wire logic                  job_full
);

    typedef enum logic [2:0] { F_IDLE, F_HASH, F_WAIT, F_PUSH, F_CLR } fstate_t;

    fstate_t       state_reg;
    logic [1:0]    k_reg;
    logic [NB-1:0] q0_reg;
    logic [NB-1:0] q1_reg;
    logic [NB-1:0] q2_reg;
    logic [NB-1:0] q3_reg;
    logic [SB-1:0] slot_reg;

    logic [NB-1:0] lo;
    logic [NB-1:0] hi;
    logic          hash_done;
    logic [63:0]   hash;

    // The current edge is always q0 -> q1; the corners rotate after each edge.
    assign lo = (q0_reg < q1_reg) ? q0_reg : q1_reg;
    assign hi = (q0_reg < q1_reg) ? q1_reg : q0_reg;

    medht_hash #(.NB(NB)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == F_HASH),
        .lo    (lo),
        .hi    (hi),
        .done  (hash_done),
        .hash  (hash)
    );

    assign item_ready = (state_reg == F_IDLE);
    assign job_push   = !job_full && (state_reg == F_PUSH || state_reg == F_CLR);
    assign job = (state_reg == F_CLR)
               ? {medht_pkg::OP_CLEAR, 1'b0, (JW - 2)'(0)}
               : {medht_pkg::OP_QUAD, (k_reg == 2'd3), slot_reg, q0_reg, q1_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            k_reg     <= 2'd0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (item_valid)
                    begin
                        q0_reg <= NB'(item.corner0);
                        q1_reg <= NB'(item.corner1);
                        q2_reg <= NB'(item.corner2);
                        q3_reg <= NB'(item.corner3);
                        k_reg  <= 2'd0;
                        state_reg <= (item.opcode == medht_pkg::OP_CLEAR) ? F_CLR : F_HASH;
                    end
                end
                F_HASH:
                begin
                    state_reg <= F_WAIT;
                end
                F_WAIT:
                begin
                    if (hash_done)
                    begin
                        slot_reg  <= hash[SB-1:0];
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!job_full)
                    begin
                        q0_reg <= q1_reg;
                        q1_reg <= q2_reg;
                        q2_reg <= q3_reg;
                        q3_reg <= q0_reg;
                        k_reg  <= k_reg + 2'd1;
                        state_reg <= (k_reg == 2'd3) ? F_IDLE : F_HASH;
                    end
                end
                F_CLR:
                begin
                    if (!job_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* sv/medht_queue.sv */
// Short first-in first-out queue of edge jobs between the front and back parts.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module medht_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      rdata,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == CW'(0));
    assign rdata = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? PW'(0) : wr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? PW'(0) : rd_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

endmodule
`default_nettype wire

/* sv/medht_probe.sv */
// Back part: linear probing in the slot RAM, insertion, clearing sweeps, result register.
// Instantiates medht_ram. Uses medht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module medht_probe #(
    parameter int SLOTS = 4096,
    parameter int NB    = 20,
    parameter int SB    = 12,
    parameter int JW    = 2 + SB + 2 * NB
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [JW-1:0]     job,
    input  wire logic              job_empty,
    output logic                   job_pop,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output medht_pkg::result_t     result
);

    localparam int EW = 2 + SB + 2 * NB;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] { P_SWEEP, P_IDLE, P_RD, P_CMP, P_EMIT } pstate_t;

    pstate_t            state_reg;
    logic [SB-1:0]      idx_reg;
    logic [SB-1:0]      slot_reg;
    logic [SB-1:0]      n_reg;
    logic [NB-1:0]      a_reg;
    logic [NB-1:0]      b_reg;
    logic               last_reg;
    logic [CW-1:0]      cnt_reg;
    medht_pkg::result_t res_reg;
    medht_pkg::result_t result_reg;
    logic               result_valid_reg;

    logic          ram_we;
    logic [SB-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    logic          flip;
    logic [NB-1:0] lo;
    logic [NB-1:0] hi;
    logic          s_used;
    logic          s_flip;
    logic [SB-1:0] s_edge;
    logic [2*NB-1:0] s_key;
    logic [CW-1:0] cnt_inc;
    logic          out_free;

    always_comb
    begin
        flip    = a_reg > b_reg;
        lo      = flip ? b_reg : a_reg;
        hi      = flip ? a_reg : b_reg;
        s_used  = ram_rdata[EW-1];
        s_flip  = ram_rdata[EW-2];
        s_edge  = ram_rdata[2*NB +: SB];
        s_key   = ram_rdata[2*NB-1:0];
        cnt_inc = cnt_reg + CW'(1);
        out_free = !result_valid_reg || result_ready;
        ram_we    = (state_reg == P_SWEEP) || (state_reg == P_CMP && !s_used);
        ram_waddr = (state_reg == P_SWEEP) ? idx_reg : slot_reg;
        ram_wdata = (state_reg == P_SWEEP) ? EW'(0)
                  : {1'b1, flip, SB'(cnt_reg), lo, hi};
    end

    assign job_pop = (state_reg == P_IDLE) && !job_empty;

    medht_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == P_RD),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= P_SWEEP;
            idx_reg          <= '0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                P_SWEEP:
                begin
                    idx_reg <= idx_reg + SB'(1);
                    if (idx_reg == SB'(SLOTS - 1))
                    begin
                        state_reg <= P_IDLE;
                    end
                end
                P_IDLE:
                begin
                    if (!job_empty)
                    begin
                        if (job[JW-1] == medht_pkg::OP_CLEAR)
                        begin
                            idx_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= P_SWEEP;
                        end
                        else
                        begin
                            last_reg  <= job[JW-2];
                            slot_reg  <= job[2*NB +: SB];
                            a_reg     <= job[2*NB-1:NB];
                            b_reg     <= job[NB-1:0];
                            n_reg     <= '0;
                            state_reg <= P_RD;
                        end
                    end
                end
                P_RD:
                begin
                    state_reg <= P_CMP;
                end
                P_CMP:
                begin
                    res_reg.last <= last_reg;
                    if (!s_used)
                    begin
                        res_reg.edge_id    <= medht_pkg::ID_W'(cnt_reg);
                        res_reg.reversed   <= 1'b0;
                        res_reg.is_new     <= 1'b1;
                        res_reg.start_node <= medht_pkg::CORNER_W'(a_reg);
                        res_reg.end_node   <= medht_pkg::CORNER_W'(b_reg);
                        res_reg.edge_count <= medht_pkg::COUNT_W'(cnt_inc);
                        res_reg.overflow   <= 1'b0;
                        cnt_reg            <= cnt_inc;
                        state_reg          <= P_EMIT;
                    end
                    else if (s_key == {lo, hi})
                    begin
                        res_reg.edge_id    <= medht_pkg::ID_W'(s_edge);
                        res_reg.reversed   <= flip != s_flip;
                        res_reg.is_new     <= 1'b0;
                        res_reg.start_node <= medht_pkg::CORNER_W'(s_flip ? hi : lo);
                        res_reg.end_node   <= medht_pkg::CORNER_W'(s_flip ? lo : hi);
                        res_reg.edge_count <= medht_pkg::COUNT_W'(cnt_reg);
                        res_reg.overflow   <= 1'b0;
                        state_reg          <= P_EMIT;
                    end
                    else if (n_reg == SB'(SLOTS - 1))
                    begin
                        // Every slot holds another key: the edge cannot be stored.
                        res_reg.edge_id    <= '0;
                        res_reg.reversed   <= 1'b0;
                        res_reg.is_new     <= 1'b0;
                        res_reg.start_node <= medht_pkg::CORNER_W'(a_reg);
                        res_reg.end_node   <= medht_pkg::CORNER_W'(b_reg);
                        res_reg.edge_count <= medht_pkg::COUNT_W'(cnt_reg);
                        res_reg.overflow   <= 1'b1;
                        state_reg          <= P_EMIT;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + SB'(1);
                        n_reg     <= n_reg + SB'(1);
                        state_reg <= P_RD;
                    end
                end
                P_EMIT:
                begin
                    if (out_free)
                    begin
                        result_reg       <= res_reg;
                        result_valid_reg <= 1'b1;
                        state_reg        <= P_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

/* sv/mesh_edge_dedup_hash_table.sv */
// Mesh edge numbering block: quads in, one result per quad edge out.
//
// The item channel (item_valid/item_ready/item) takes either a quad of four
// corner node indices or a clear command. A quad yields four result items on
// the result channel (result_valid/result_ready/result), in the edge order
// q0-q1, q1-q2, q2-q3, q3-q0, the fourth marked with last. A clear command
// empties the table and the edge counter and yields no result.
// The front part hashes each edge with one shared 32x32 multiplier and then
// queues it; it takes a new quad only after every edge of the current
// one is queued. The back part takes a job, then reads and compares one
// slot per probe, stepping to the next slot on a mismatch, and hands the
// result to the result register; long probe chains add a read and compare
// per extra slot.
// After reset and after each clear, the back part sweeps all
// TABLE_SLOTS slots before it handles the next edge; items are still taken
// into the two-entry job queue meanwhile. A stalled receiver holds the
// result register; the back part then waits, and the front part stalls once
// the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module mesh_edge_dedup_hash_table #(
    parameter int TABLE_SLOTS = 4096,
    parameter int NODE_BITS   = 20
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire medht_pkg::item_t    item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output medht_pkg::result_t       result
);

    localparam int SB = $clog2(TABLE_SLOTS);
    localparam int JW = 2 + SB + 2 * NODE_BITS;

    logic          job_push;
    logic [JW-1:0] job_in;
    logic          job_full;
    logic          job_pop;
    logic [JW-1:0] job_out;
    logic          job_empty;

    medht_front #(.NB(NODE_BITS), .SB(SB), .JW(JW)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .job_push   (job_push),
        .job        (job_in),
        .job_full   (job_full)
    );

    medht_queue #(.W(JW), .DEPTH(2)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_out),
        .empty (job_empty)
    );

    medht_probe #(.SLOTS(TABLE_SLOTS), .NB(NODE_BITS), .SB(SB), .JW(JW)) u_probe (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job_out),
        .job_empty    (job_empty),
        .job_pop      (job_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // An edge that could not be stored carries no id and is never new.
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overflow |-> !result.is_new && result.edge_id == '0)
        else $error("overflow result carries an id");

    // A freshly inserted edge takes the id just below the updated count.
    a_new_id: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_new
        |-> (result.edge_id + 12'd1) == result.edge_count[11:0])
        else $error("new edge id does not match edge count");

    // A new edge keeps its own orientation.
    a_new_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_new |-> !result.reversed)
        else $error("new edge reported as reversed");

endmodule
`default_nettype wire
